// ===== hdl/hgc_pkg.sv =====
// constants, types and helpers for the hash group count core
package hgc_pkg;

  localparam int TABLE_SLOTS = 4096;
  localparam int BLOCK_SLOTS = 16;
  localparam int KEY_BITS    = 32;
  localparam int COUNT_BITS  = 32;

  localparam int NUM_BLOCKS = (TABLE_SLOTS + BLOCK_SLOTS - 1) / BLOCK_SLOTS;
  localparam int SLOT_W     = $clog2(TABLE_SLOTS);
  localparam int OFF_W      = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [BLOCK_SLOTS-1:0] mask_t;
  typedef logic [OFF_W-1:0]       off_t;
  typedef logic [BLK_W-1:0]       blk_t;

  // command codes carried in tuser
  localparam logic CMD_COUNT  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MREQ = 7'b0000010,
    S_MASK = 7'b0000100,
    S_KREQ = 7'b0001000,
    S_KCMP = 7'b0010000,
    S_FREE = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  // index of the lowest set bit, zero when none is set
  function automatic off_t lowest_set(input mask_t m);
    off_t idx;
    idx = '0;
    for (int i = BLOCK_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) idx = off_t'(i);
    end
    return idx;
  endfunction

  // one-hot mask of slot idx
  function automatic mask_t slot_bit(input off_t idx);
    mask_t m;
    m = '0;
    for (int i = 0; i < BLOCK_SLOTS; i++) begin
      if (off_t'(i) == idx) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== hdl/hash_group_count_linear_probe_core.sv =====
// hash group count core: per-key occurrence counter over a block-probed hash table
// Each input word carries a key in tdata and the command in tuser (0 counts one
// occurrence, 1 looks up the stored count); each one produces exactly one output
// word with the count in tdata and {table_full, was_new} in tuser. The key's low
// bits pick a home block of 16 slots; a small sequencer reads the block's slot
// occupancy mask, then walks the occupied slots one at a time through a single
// key compare on registered memory reads. On a miss a count claims the lowest free
// slot and a lookup stops there; if the block is full, either moves on to the next
// block with wrap-around. The key/count memory has one read port, so each compared
// slot takes a request state and a compare state, and each extra full block visited
// passes through the free, mask request and mask states again. A waiting output word
// holds the sequencer in its done state, and no new input word is taken until the
// last one's output word is loaded. The table is empty after reset with no clearing
// pass: a per-block flag marks blocks whose occupancy mask has ever been written.
module hash_group_count_linear_probe_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [31:0]             s_axis_tdata_i,   // [31:0] key
  input  logic [0:0]              s_axis_tuser_i,   // [0] command
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [31:0]             m_axis_tdata_o,   // [31:0] count
  output logic [1:0]              m_axis_tuser_o    // [0] was_new, [1] table_full
);
  import hgc_pkg::*;

  state_e state_q, state_d;

  logic   cmd_q;
  key_t   key_q;
  blk_t   blk_q;
  blk_t   visited_q;
  mask_t  mask_q;
  mask_t  remain_q;
  off_t   slot_q;

  count_t res_count_q;
  logic   res_new_q;
  logic   res_full_q;

  logic   out_valid_q;
  count_t out_count_q;
  logic   out_new_q;
  logic   out_full_q;

  // memories, one row per block for the occupancy mask
  key_t   key_mem [TABLE_SLOTS];
  count_t cnt_mem [TABLE_SLOTS];
  mask_t  mask_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] row_ok_q;

  key_t   key_rd_q;
  count_t cnt_rd_q;
  mask_t  mask_rd_q;

  logic   in_acc;
  off_t   sel_slot;
  off_t   free_slot;
  logic   has_free;
  logic   key_hit;
  count_t cnt_inc;

  logic [SLOT_W-1:0] rd_addr;
  logic              cnt_we;
  logic [SLOT_W-1:0] cnt_waddr;
  count_t            cnt_wdata;
  logic              key_we;
  logic              mask_we;
  logic              out_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign sel_slot  = lowest_set(remain_q);
  assign free_slot = lowest_set(~mask_q);
  assign has_free  = ~&mask_q;
  assign key_hit   = (key_rd_q == key_q);
  assign cnt_inc   = (cnt_rd_q == COUNT_MAX) ? cnt_rd_q : cnt_rd_q + count_t'(1);
  assign rd_addr   = SLOT_W'({blk_q, sel_slot});
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  // write strobes of the memories
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = SLOT_W'({blk_q, slot_q});
    cnt_wdata = cnt_inc;
    key_we    = 1'b0;
    mask_we   = 1'b0;
    if (state_q == S_KCMP && key_hit && cmd_q == CMD_COUNT) begin
      cnt_we = 1'b1;
    end
    if (state_q == S_FREE && has_free && cmd_q == CMD_COUNT) begin
      cnt_we    = 1'b1;
      cnt_waddr = SLOT_W'({blk_q, free_slot});
      cnt_wdata = count_t'(1);
      key_we    = 1'b1;
      mask_we   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (key_we) key_mem[cnt_waddr] <= key_q;
    key_rd_q <= key_mem[rd_addr];
    cnt_rd_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mask_we) mask_mem[blk_q] <= mask_q | slot_bit(free_slot);
    mask_rd_q <= mask_mem[blk_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ok_q <= '0;
    end else if (mask_we) begin
      row_ok_q[blk_q] <= 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_MREQ;
      S_MREQ: state_d = S_MASK;
      S_MASK: begin
        if (row_ok_q[blk_q] && (mask_rd_q != '0)) state_d = S_KREQ;
        else                                      state_d = S_FREE;
      end
      S_KREQ: state_d = S_KCMP;
      S_KCMP: begin
        if (key_hit)             state_d = S_DONE;
        else if (remain_q != '0) state_d = S_KREQ;
        else                     state_d = S_FREE;
      end
      S_FREE: begin
        if (has_free || visited_q == blk_t'(NUM_BLOCKS - 1)) state_d = S_DONE;
        else                                                 state_d = S_MREQ;
      end
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)             out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_q       <= s_axis_tuser_i[0];
          key_q       <= s_axis_tdata_i;
          blk_q       <= blk_t'(s_axis_tdata_i[SLOT_W-1:OFF_W]);
          visited_q   <= '0;
          res_count_q <= '0;
          res_new_q   <= 1'b0;
          res_full_q  <= 1'b0;
        end
      end
      S_MASK: begin
        mask_q   <= row_ok_q[blk_q] ? mask_rd_q : '0;
        remain_q <= row_ok_q[blk_q] ? mask_rd_q : '0;
      end
      S_KREQ: begin
        slot_q   <= sel_slot;
        remain_q <= remain_q & ~slot_bit(sel_slot);
      end
      S_KCMP: begin
        if (key_hit) res_count_q <= (cmd_q == CMD_COUNT) ? cnt_inc : cnt_rd_q;
      end
      S_FREE: begin
        if (has_free) begin
          if (cmd_q == CMD_COUNT) begin
            res_count_q <= count_t'(1);
            res_new_q   <= 1'b1;
          end
        end else if (visited_q == blk_t'(NUM_BLOCKS - 1)) begin
          res_full_q <= (cmd_q == CMD_COUNT);
        end else begin
          // block is full, move on with wrap-around
          visited_q <= visited_q + blk_t'(1);
          blk_q     <= (blk_q == blk_t'(NUM_BLOCKS - 1)) ? '0 : blk_q + blk_t'(1);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_count_q <= res_count_q;
      out_new_q   <= res_new_q;
      out_full_q  <= res_full_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_count_q;
  assign m_axis_tuser_o  = {out_full_q, out_new_q};

endmodule

// ===== test/hgc_count_monitor.sv =====
// monitor for the hash group count core: models the table and checks every output word
module hgc_count_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  input  logic                           s_ready_i,
  input  logic [31:0]                    s_data_i,    // [31:0] key
  input  logic [0:0]                     s_user_i,    // [0] command
  input  logic                           m_valid_i,
  input  logic                           m_ready_i,
  input  logic [31:0]                    m_data_i,    // [31:0] count
  input  logic [1:0]                     m_user_i,    // [0] was_new, [1] table_full
  output int                             errors_o,
  output logic [hgc_pkg::TABLE_SLOTS-1:0] slot_used_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hgc_pkg::*;

  typedef struct packed {
    count_t count;
    logic   was_new;
    logic   table_full;
  } tally_t;

  key_t   tbl_key  [TABLE_SLOTS];
  count_t tbl_cnt  [TABLE_SLOTS];
  logic   tbl_used [TABLE_SLOTS];
  tally_t tally_due[$];

  // walks the blocks from the key's home block, updates the table, returns the output word
  function automatic tally_t probe_table(input logic cmd, input key_t key, output int claimed);
    tally_t res;
    int     blk;
    int     hit;
    int     free_at;
    int     s;
    bit     done;
    res     = '0;
    claimed = -1;
    done    = 1'b0;
    blk     = int'(key % TABLE_SLOTS) / BLOCK_SLOTS;
    for (int n = 0; n < NUM_BLOCKS && !done; n++) begin
      hit     = -1;
      free_at = -1;
      for (int i = 0; i < BLOCK_SLOTS; i++) begin
        s = blk * BLOCK_SLOTS + i;
        if (s < TABLE_SLOTS) begin
          if (tbl_used[s]) begin
            if (hit < 0 && tbl_key[s] == key) hit = s;
          end else if (free_at < 0) begin
            free_at = s;
          end
        end
      end
      if (hit >= 0) begin
        // counts stick at the top value
        if (cmd == CMD_COUNT && tbl_cnt[hit] != COUNT_MAX) tbl_cnt[hit] = tbl_cnt[hit] + 1'b1;
        res.count = tbl_cnt[hit];
        done      = 1'b1;
      end else if (free_at >= 0) begin
        if (cmd == CMD_COUNT) begin
          tbl_key[free_at]  = key;
          tbl_cnt[free_at]  = count_t'(1);
          tbl_used[free_at] = 1'b1;
          res.count         = count_t'(1);
          res.was_new       = 1'b1;
          claimed           = free_at;
        end
        done = 1'b1;
      end else begin
        blk = (blk + 1 == NUM_BLOCKS) ? 0 : blk + 1;
      end
    end
    if (!done && cmd == CMD_COUNT) res.table_full = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want;
    tally_t got;
    int     claimed;
    if (!rst_ni) begin
      foreach (tbl_used[i]) tbl_used[i] = 1'b0;
      tally_due.delete();
      errors_o = 0;
      slot_used_o <= '0;
    end else begin
      // output first: a word leaving now belongs to an older request
      if (m_valid_i && m_ready_i) begin
        got = '{count: count_t'(m_data_i), was_new: m_user_i[0], table_full: m_user_i[1]};
        if (tally_due.size() == 0) begin
          $display("%0t: output word with no request pending, count %0d", $time, got.count);
          errors_o++;
        end else begin
          want = tally_due.pop_front();
          if (got.count !== want.count) begin
            $display("%0t: count expected %0d, got %0d", $time, want.count, got.count);
            errors_o++;
          end
          if (got.was_new !== want.was_new) begin
            $display("%0t: was_new expected %0b, got %0b", $time, want.was_new, got.was_new);
            errors_o++;
          end
          if (got.table_full !== want.table_full) begin
            $display("%0t: table_full expected %0b, got %0b", $time, want.table_full,
                     got.table_full);
            errors_o++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        tally_due.push_back(probe_table(s_user_i[0], key_t'(s_data_i), claimed));
        if (claimed >= 0) slot_used_o[claimed] <= 1'b1;
      end
    end
  end

endmodule

// ===== test/tb_hash_group_count_linear_probe_core.sv =====
// top of the hash group count testbench: clock, reset, stimulus and verdict
module tb_hash_group_count_linear_probe_core;
  timeunit 1ns;
  timeprecision 1ps;
  import hgc_pkg::*;

  localparam int   CLK_PERIOD   = 20;
  localparam int   RESET_CYCLES = 6;
  localparam int   RAND_ITEMS   = 1300;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   DRAIN_CYCLES = 50;
  localparam int   CYCLE_LIMIT  = 5_000_000;
  localparam key_t FILL_TAG     = 32'h5EED_0000;

  logic                   clk            = 1'b0;
  logic                   rst_n          = 1'b0;
  logic                   s_axis_tvalid  = 1'b0;
  logic                   s_axis_tready;
  logic [31:0]            s_axis_tdata   = '0;    // [31:0] key
  logic [0:0]             s_axis_tuser   = '0;    // [0] command
  logic                   m_axis_tvalid;
  logic                   m_axis_tready  = 1'b0;
  logic [31:0]            m_axis_tdata;           // [31:0] count
  logic [1:0]             m_axis_tuser;           // [0] was_new, [1] table_full
  int                     mismatches;
  logic [TABLE_SLOTS-1:0] slot_used;

  int   words_in    = 0;
  int   words_out   = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   hold_req    = 0;
  int   hold_seen   = 0;
  int   hold_left   = 0;
  int   cycles      = 0;
  key_t key_pool[$];

  hash_group_count_linear_probe_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  hgc_count_monitor u_monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_user_i    (m_axis_tuser),
    .errors_o    (mismatches),
    .slot_used_o (slot_used)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_hash_group_count_linear_probe_core: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) words_out <= words_out + 1;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_word(input logic cmd, input key_t key);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_in++;
  endtask

  // mix of repeated keys, keys crowding the first and last block, and fresh keys
  task automatic send_random();
    logic        cmd;
    key_t        key;
    int unsigned roll;
    int          hot_blk;
    roll = $urandom_range(0, 99);
    cmd  = ($urandom_range(0, 99) < 30) ? CMD_LOOKUP : CMD_COUNT;
    if (roll < 35 && key_pool.size() > 0) begin
      key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (roll < 55) begin
      hot_blk = ($urandom_range(0, 1) == 0) ? 0 : NUM_BLOCKS - 1;
      key = $urandom;
      key[SLOT_W-1:0] = SLOT_W'(hot_blk * BLOCK_SLOTS + $urandom_range(0, BLOCK_SLOTS - 1));
    end else begin
      key = $urandom;
    end
    if (cmd == CMD_COUNT) key_pool.push_back(key);
    send_word(cmd, key);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (words_out < words_in) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 20;
    rx_idle_pct = 69;
    // key zero is an ordinary key
    send_word(CMD_COUNT,  32'h0000_0000);
    send_word(CMD_COUNT,  32'h0000_0000);
    send_word(CMD_LOOKUP, 32'h0000_0000);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF);
    send_word(CMD_COUNT,  32'hFFFF_FFFF);
    send_word(CMD_COUNT,  32'hFFFF_FFFF);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF);
    // same home slot as key zero: takes the next free slot of block 0
    send_word(CMD_COUNT,  32'h0000_1000);
    send_word(CMD_LOOKUP, 32'h0000_2000);
    send_word(CMD_LOOKUP, 32'h0000_1000);
    send_word(CMD_COUNT,  32'h8000_0000);
    send_word(CMD_LOOKUP, 32'h8000_0000);
    send_word(CMD_COUNT,  32'h7FFF_FFFF);
    send_word(CMD_COUNT,  32'hAAAA_AAAA);
    send_word(CMD_COUNT,  32'h5555_5555);
    key_pool.push_back(32'h0000_0000);
    key_pool.push_back(32'hFFFF_FFFF);
    key_pool.push_back(32'h0000_1000);

    repeat (RAND_ITEMS / 3) send_random();
    tx_idle_pct = 69;
    rx_idle_pct = 20;
    repeat (RAND_ITEMS / 3) send_random();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req++;
    repeat (RAND_ITEMS / 3) send_random();
    wait_idle();

    // fill every free slot with a key whose home is that slot
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      if (!slot_used[s]) send_word(CMD_COUNT, FILL_TAG | key_t'(s));
    end
    // table is full: absent keys walk every block
    repeat (3) send_word(CMD_COUNT, $urandom);
    repeat (2) send_word(CMD_LOOKUP, $urandom);
    send_word(CMD_COUNT, 32'h0000_0000);
    send_word(CMD_LOOKUP, FILL_TAG | key_t'(TABLE_SLOTS - 1));
    send_word(CMD_COUNT, key_pool[$urandom_range(0, key_pool.size() - 1)]);
    wait_idle();

    if (mismatches == 0) begin
      $display("tb_hash_group_count_linear_probe_core: done, clean");
    end else begin
      $display("tb_hash_group_count_linear_probe_core: done, errors");
    end
    $finish;
  end

endmodule
